### rtl/pac_pkg.sv
// Shared types and constants for the polygon area and centroid block.
`timescale 1ns / 1ps
package pac_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int COORD_BITS_DEF   = 16;
	localparam int QDEPTH           = 4;
	localparam int QPW              = 2;
	localparam int QCW              = 3;

	// One queue entry: an edge to add and, on the last vertex, the closing edge
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] ca;
		logic [31:0] cb;
		logic        edge_en;
		logic        close;
		logic        few;
	} pac_entry_t;

	typedef enum logic [3:0] {
		B_IDLE, B_MUL, B_SUM, B_PROD, B_ACC, B_CHECK, B_DIVX, B_DIVY, B_OUT
	} pac_bstate_t;

	typedef enum logic [1:0] {
		D_IDLE, D_PREP, D_ITER, D_DONE
	} pac_dstate_t;

endpackage

### rtl/polygon_area_centroid.sv
// Top level of the polygon area and centroid block.
//
//  channel  | dir | tdata fields (low bit up)             | tlast        | tuser
//  s_axis   | in  | vertex_x[15:0], vertex_y[31:16]        | last_vertex  | -
//  m_axis   | out | centroid_x[23:0], centroid_y[47:24]    | -            | degenerate
//
// Each edge passes the accumulator steps multiply, sum, weighted multiply and
// add; a new edge is popped from the queue only once the last one is added.
// A last vertex adds the closing edge and, unless degenerate, two divisions,
// x and then y, on one shared divider.
// The 4-entry edge queue lets intake run ahead; s_axis_tready drops only when full.
// Reset is asynchronous, clearing sums and intake/queue counters; no clearing pass.
`timescale 1ns / 1ps
module polygon_area_centroid #(
	parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = pac_pkg::COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // vertex_x[15:0], vertex_y[31:16]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // centroid_x[23:0], centroid_y[47:24]
	output logic        m_axis_tuser   // degenerate
);

	pac_pkg::pac_entry_t push_entry, pop_entry;
	logic push, pop, full, empty;

	pac_front #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.q_full   (full),
		.q_push   (push),
		.q_entry  (push_entry)
	);

	pac_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.pop       (pop),
		.pop_data  (pop_entry),
		.full      (full),
		.empty     (empty)
	);

	pac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (empty),
		.q_pop     (pop),
		.q_entry   (pop_entry),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_deg   (m_axis_tuser)
	);

endmodule

### rtl/pac_front.sv
// Vertex intake: tracks first and previous point and turns vertices into edges.
`timescale 1ns / 1ps
module pac_front #(
	parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = pac_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        in_data,
	input  logic               in_last,
	input  logic               q_full,
	output logic               q_push,
	output pac_pkg::pac_entry_t q_entry
);

	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int SH = 16 - COORD_BITS;

	logic [31:0]    first_q;
	logic [31:0]    prev_q;
	logic [CW-1:0]  count_q;
	logic signed [15:0] xs;
	logic signed [15:0] ys;
	logic [31:0]    pt;
	logic           accept;
	logic           kept;
	logic [31:0]    prev_nx;
	logic [31:0]    first_nx;
	logic [CW-1:0]  count_nx;

	// Sign-extend the used coordinate bits and classify the vertex
	always_comb begin
		xs       = $signed(in_data[15:0] << SH) >>> SH;
		ys       = $signed(in_data[31:16] << SH) >>> SH;
		pt       = {ys, xs};
		accept   = in_valid && in_ready;
		kept     = count_q < CW'(MAX_VERTICES);
		prev_nx  = kept ? pt : prev_q;
		first_nx = (kept && count_q == '0) ? pt : first_q;
		count_nx = kept ? count_q + CW'(1) : count_q;
		in_ready = !q_full;
		q_entry.a       = prev_q;
		q_entry.b       = pt;
		q_entry.edge_en = kept && count_q != '0;
		q_entry.close   = in_last;
		q_entry.ca      = prev_nx;
		q_entry.cb      = first_nx;
		q_entry.few     = count_nx < CW'(3);
		q_push = accept && (q_entry.edge_en || in_last);
	end

	// Advance vertex state; restart after the last vertex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			prev_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			first_q <= first_nx;
			prev_q  <= prev_nx;
			count_q <= in_last ? '0 : count_nx;
		end
	end

endmodule

### rtl/pac_queue.sv
// Short edge queue between vertex intake and the accumulator.
`timescale 1ns / 1ps
module pac_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pac_pkg::pac_entry_t push_data,
	input  logic                pop,
	output pac_pkg::pac_entry_t pop_data,
	output logic                full,
	output logic                empty
);

	pac_pkg::pac_entry_t            mem_q [pac_pkg::QDEPTH];
	logic [pac_pkg::QPW-1:0]        wr_q;
	logic [pac_pkg::QPW-1:0]        rd_q;
	logic [pac_pkg::QCW-1:0]        cnt_q;

	assign full     = cnt_q == pac_pkg::QCW'(pac_pkg::QDEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### rtl/pac_div.sv
// Restoring divider: moment / (3 * area) with 8 fraction bits, rounded, saturated.
`timescale 1ns / 1ps
module pac_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [60:0] moment,
	input  logic signed [43:0] area,
	output logic               done,
	output logic [23:0]        result
);

	pac_pkg::pac_dstate_t state_q, state_d;
	logic        neg_q;
	logic [60:0] num_q;
	logic [45:0] den_q;
	logic [71:0] rem_q;
	logic [71:0] dsh_q;
	logic        ovf_q;
	logic [24:0] quo_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [23:0] res_q;
	logic [43:0] abs_a;
	logic [71:0] n_full;
	logic [71:0] d_top;
	logic        take;
	logic [24:0] quo_nx;
	logic [23:0] sat;

	assign done   = done_q;
	assign result = res_q;

	// Operand conditioning, one trial subtract and final saturation
	always_comb begin
		abs_a  = area[43] ? 44'(-area) : 44'(area);
		n_full = {2'b0, num_q, 9'b0} + 72'(den_q);
		d_top  = 72'(den_q) << 26;
		take   = rem_q >= dsh_q;
		quo_nx = {quo_q[23:0], take};
		if (neg_q) begin
			if (ovf_q || quo_nx > 25'h800000) sat = 24'h800000;
			else sat = 24'(-quo_nx);
		end else begin
			if (ovf_q || quo_nx > 25'h7FFFFF) sat = 24'h7FFFFF;
			else sat = quo_nx[23:0];
		end
	end

	// Next state; a new start may follow directly on the done cycle
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pac_pkg::D_IDLE: if (start) state_d = pac_pkg::D_PREP;
			pac_pkg::D_PREP: state_d = pac_pkg::D_ITER;
			pac_pkg::D_ITER: if (cnt_q == '0) state_d = pac_pkg::D_DONE;
			pac_pkg::D_DONE: state_d = start ? pac_pkg::D_PREP : pac_pkg::D_IDLE;
			default: state_d = pac_pkg::D_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pac_pkg::D_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == pac_pkg::D_ITER && cnt_q == '0;
		end
	end

	// Datapath: latch magnitudes, set up, then one quotient bit per cycle
	always_ff @(posedge clk) begin
		case (state_q) inside
			pac_pkg::D_IDLE, pac_pkg::D_DONE: begin
				neg_q <= moment[60] ^ area[43];
				num_q <= moment[60] ? 61'(-moment) : 61'(moment);
				den_q <= 46'(abs_a) + (46'(abs_a) << 1);
			end
			pac_pkg::D_PREP: begin
				rem_q <= n_full;
				dsh_q <= d_top >> 1;
				ovf_q <= n_full >= d_top;
				quo_q <= '0;
				cnt_q <= 5'd24;
			end
			pac_pkg::D_ITER: begin
				if (take) rem_q <= rem_q - dsh_q;
				dsh_q <= dsh_q >> 1;
				quo_q <= quo_nx;
				cnt_q <= cnt_q - 5'd1;
				res_q <= sat;
			end
			default: ;
		endcase
	end

endmodule

### rtl/pac_back.sv
// Edge accumulator: shoelace sums, closing edge, division and result register.
`timescale 1ns / 1ps
module pac_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	output logic                q_pop,
	input  pac_pkg::pac_entry_t q_entry,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [47:0]         out_data,
	output logic                out_deg
);

	pac_pkg::pac_bstate_t state_q, state_d;
	logic signed [15:0] x1_q, y1_q, x2_q, y2_q;
	logic [31:0]        ca_q, cb_q;
	logic               close_q, closing_q, few_q;
	logic signed [31:0] pa_q, pb_q, pc_q, pd_q, y11_q, y12_q, y22_q;
	logic signed [16:0] dx_q, sa_q;
	logic signed [34:0] sx_q;
	logic signed [33:0] sy_q;
	logic signed [33:0] ta_q;
	logic signed [51:0] tx_q;
	logic signed [50:0] ty_q;
	logic signed [43:0] area_q;
	logic signed [60:0] mx_q, my_q;
	logic [23:0]        rx_q, ry_q;
	logic               rdeg_q;
	logic               ov_q;
	logic [47:0]        od_q;
	logic               odeg_q;
	logic               div_start;
	logic               div_done;
	logic [23:0]        div_res;
	logic               out_free;

	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign out_deg   = odeg_q;
	assign out_free  = !ov_q || out_ready;

	pac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.moment (state_q == pac_pkg::B_DIVX ? my_q : mx_q),
		.area   (area_q),
		.done   (div_done),
		.result (div_res)
	);

	// Next state and handshake strobes
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			pac_pkg::B_IDLE: if (!q_empty) begin
				q_pop   = 1'b1;
				state_d = pac_pkg::B_MUL;
			end
			pac_pkg::B_MUL:  state_d = pac_pkg::B_SUM;
			pac_pkg::B_SUM:  state_d = pac_pkg::B_PROD;
			pac_pkg::B_PROD: state_d = pac_pkg::B_ACC;
			pac_pkg::B_ACC: begin
				if (close_q && !closing_q) state_d = pac_pkg::B_MUL;
				else if (close_q) state_d = pac_pkg::B_CHECK;
				else state_d = pac_pkg::B_IDLE;
			end
			pac_pkg::B_CHECK: begin
				if (few_q || area_q == '0) begin
					state_d = pac_pkg::B_OUT;
				end else begin
					div_start = 1'b1;
					state_d   = pac_pkg::B_DIVX;
				end
			end
			pac_pkg::B_DIVX: if (div_done) begin
				div_start = 1'b1;
				state_d   = pac_pkg::B_DIVY;
			end
			pac_pkg::B_DIVY: if (div_done) state_d = pac_pkg::B_OUT;
			pac_pkg::B_OUT:  if (out_free) state_d = pac_pkg::B_IDLE;
			default: state_d = pac_pkg::B_IDLE;
		endcase
	end

	// Control registers: state, sums and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pac_pkg::B_IDLE;
			area_q  <= '0;
			mx_q    <= '0;
			my_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pac_pkg::B_ACC) begin
				area_q <= area_q + 44'(ta_q);
				mx_q   <= mx_q + 61'(tx_q);
				my_q   <= my_q + 61'(ty_q);
			end
			if (state_q == pac_pkg::B_OUT && out_free) begin
				area_q <= '0;
				mx_q   <= '0;
				my_q   <= '0;
				ov_q   <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Edge datapath: operands, products, sums, weighted products; then division results and output register
	always_ff @(posedge clk) begin
		if (state_q == pac_pkg::B_IDLE && !q_empty) begin
			ca_q      <= q_entry.ca;
			cb_q      <= q_entry.cb;
			close_q   <= q_entry.close;
			few_q     <= q_entry.few;
			closing_q <= !q_entry.edge_en;
			if (q_entry.edge_en) begin
				x1_q <= $signed(q_entry.a[15:0]);
				y1_q <= $signed(q_entry.a[31:16]);
				x2_q <= $signed(q_entry.b[15:0]);
				y2_q <= $signed(q_entry.b[31:16]);
			end else begin
				x1_q <= $signed(q_entry.ca[15:0]);
				y1_q <= $signed(q_entry.ca[31:16]);
				x2_q <= $signed(q_entry.cb[15:0]);
				y2_q <= $signed(q_entry.cb[31:16]);
			end
		end
		if (state_q == pac_pkg::B_ACC && close_q && !closing_q) begin
			closing_q <= 1'b1;
			x1_q      <= $signed(ca_q[15:0]);
			y1_q      <= $signed(ca_q[31:16]);
			x2_q      <= $signed(cb_q[15:0]);
			y2_q      <= $signed(cb_q[31:16]);
		end
		if (state_q == pac_pkg::B_MUL) begin
			pa_q  <= x1_q * y1_q;
			pb_q  <= x1_q * y2_q;
			pc_q  <= x2_q * y1_q;
			pd_q  <= x2_q * y2_q;
			y11_q <= y1_q * y1_q;
			y12_q <= y1_q * y2_q;
			y22_q <= y2_q * y2_q;
			dx_q  <= 17'(x2_q) - 17'(x1_q);
			sa_q  <= 17'(y1_q) + 17'(y2_q);
		end
		if (state_q == pac_pkg::B_SUM) begin
			sx_q <= (35'(pa_q) <<< 1) + 35'(pb_q) + 35'(pc_q) + (35'(pd_q) <<< 1);
			sy_q <= 34'(y11_q) + 34'(y12_q) + 34'(y22_q);
		end
		if (state_q == pac_pkg::B_PROD) begin
			ta_q <= dx_q * sa_q;
			tx_q <= dx_q * sx_q;
			ty_q <= dx_q * sy_q;
		end
		if (state_q == pac_pkg::B_CHECK) begin
			rdeg_q <= few_q || area_q == '0;
			rx_q   <= '0;
			ry_q   <= '0;
		end
		if (state_q == pac_pkg::B_DIVX && div_done) rx_q <= div_res;
		if (state_q == pac_pkg::B_DIVY && div_done) ry_q <= div_res;
		if (state_q == pac_pkg::B_OUT && out_free) begin
			od_q   <= {ry_q, rx_q};
			odeg_q <= rdeg_q;
		end
	end

endmodule

### rtl/pac_checker.sv
// Port-level checks for the polygon area and centroid block, bound to the top.
`timescale 1ns / 1ps
module pac_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// Drop valid only after a transaction
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_axis_tvalid) |-> $past(m_axis_tready))
		else $error("result dropped without transaction");

	// Degenerate results carry a zero centroid
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("degenerate result with nonzero centroid");

	// Ready holds while no vertex is offered, as the queue fills only on accepted vertices
	a_ready_keep: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready && !s_axis_tvalid |=> s_axis_tready)
		else $error("input ready dropped without transaction");

endmodule

bind polygon_area_centroid pac_checker u_pac_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
